@@ rtl/rshf_pkg.sv @@
// ----------------------------------------------------------------------------
// rshf_pkg
// Shared types, constants and pairing functions of the RNA stem helix finder.
// ----------------------------------------------------------------------------
package rshf_pkg;

   // Sequence store capacity and derived widths.
   localparam int MAX_LEN = 256;
   localparam int ADDR_W  = $clog2(MAX_LEN);
   localparam int CNT_W   = ADDR_W + 1;
   localparam int RUN_W   = 8;

   // Command codes of a request beat.
   localparam logic [1:0] OP_CLEAR = 2'd0;
   localparam logic [1:0] OP_LOAD  = 2'd1;
   localparam logic [1:0] OP_FETCH = 2'd2;

   // Nucleotide codes; two positions pair when their codes sum to a pair code.
   localparam logic [3:0] CODE_NONE = 4'd0;
   localparam logic [3:0] CODE_A    = 4'd1;
   localparam logic [3:0] CODE_U    = 4'd2;
   localparam logic [3:0] CODE_G    = 4'd4;
   localparam logic [3:0] CODE_C    = 4'd8;
   localparam logic [4:0] PAIR_AU   = 5'd3;
   localparam logic [4:0] PAIR_GU   = 5'd6;
   localparam logic [4:0] PAIR_GC   = 5'd12;

   // Request and response beats.
   typedef struct packed {
      logic [1:0] op;
      logic [7:0] base;
   } req_type;

   typedef struct packed {
      logic       found;
      logic [7:0] outer_left;
      logic [7:0] outer_right;
      logic [7:0] length;
      logic       overflow;
   } rsp_type;

   // Operands of one dot plot cell as seen by the cell unit.
   typedef struct packed {
      logic [CNT_W-1:0] row;
      logic [CNT_W-1:0] col;
      logic [CNT_W-1:0] count;
      logic [3:0]       base_row;
      logic [3:0]       base_col;
      logic [RUN_W-1:0] run_old;
      logic [RUN_W-1:0] run_next;
      logic             prev_pair;
      logic [7:0]       min_length;
   } cell_in_type;

   // Outcome of one dot plot cell.
   typedef struct packed {
      logic             emit;
      logic             pair_now;
      logic [RUN_W-1:0] run_new;
      logic [7:0]       outer_left;
      logic [7:0]       outer_right;
      logic [7:0]       length;
   } cell_out_type;

   // Map an ASCII character to its nucleotide code.
   function automatic logic [3:0] base_code(input logic [7:0] ch);
      logic [3:0] code;
      case (ch)
         8'h41:   code = CODE_A;
         8'h55:   code = CODE_U;
         8'h54:   code = CODE_U;
         8'h47:   code = CODE_G;
         8'h43:   code = CODE_C;
         default: code = CODE_NONE;
      endcase
      return code;
   endfunction

   // True when two nucleotide codes form a Watson-Crick or wobble pair.
   function automatic logic codes_pair(input logic [3:0] a, input logic [3:0] b);
      logic [4:0] sum;
      sum = {1'b0, a} + {1'b0, b};
      return sum inside {PAIR_AU, PAIR_GU, PAIR_GC};
   endfunction

endpackage

@@ rtl/rshf_base_store.sv @@
// ----------------------------------------------------------------------------
// rshf_base_store
// Sequence memory with fill count and overflow flag; two registered read ports.
// ----------------------------------------------------------------------------
module rshf_base_store import rshf_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              clear,
   input  logic              load,
   input  logic [7:0]        load_char,
   input  logic [ADDR_W-1:0] rd_addr_a,
   input  logic [ADDR_W-1:0] rd_addr_b,
   output logic [3:0]        rd_data_a,
   output logic [3:0]        rd_data_b,
   output logic [CNT_W-1:0]  count,
   output logic              overflow
);

   logic [3:0]       mem [MAX_LEN];
   logic [CNT_W-1:0] count_ff, count_in;
   logic             overflow_ff, overflow_in;
   logic             full;
   logic [3:0]       rd_a_ff, rd_b_ff;

   assign full = (count_ff == CNT_W'(MAX_LEN));

   // Fill count and overflow flag.
   always_comb begin
      count_in    = count_ff;
      overflow_in = overflow_ff;
      if (clear) begin
         count_in    = '0;
         overflow_in = 1'b0;
      end else if (load) begin
         if (full) begin
            overflow_in = 1'b1;
         end else begin
            count_in = count_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff    <= '0;
         overflow_ff <= 1'b0;
      end else begin
         count_ff    <= count_in;
         overflow_ff <= overflow_in;
      end
   end

   // Memory write of a loaded character and registered reads.
   always_ff @(posedge clock) begin
      if (load && !clear && !full) begin
         mem[count_ff[ADDR_W-1:0]] <= base_code(load_char);
      end
      rd_a_ff <= mem[rd_addr_a];
      rd_b_ff <= mem[rd_addr_b];
   end

   assign rd_data_a = rd_a_ff;
   assign rd_data_b = rd_b_ff;
   assign count     = count_ff;
   assign overflow  = overflow_ff;

endmodule

@@ rtl/rshf_cell_unit.sv @@
// ----------------------------------------------------------------------------
// rshf_cell_unit
// Evaluates one dot plot cell: pair test, run update and helix end detection.
// ----------------------------------------------------------------------------
module rshf_cell_unit import rshf_pkg::*; (
   input  cell_in_type  cell_in,
   output cell_out_type cell_out
);

   logic [RUN_W-1:0] old_run;
   logic [RUN_W-1:0] next_run;
   logic             first_row;
   logic             last_col;
   logic             above_diag;
   logic             run_continues;
   logic [CNT_W-1:0] col_plus;
   logic [CNT_W-1:0] left_full;
   logic [CNT_W-1:0] right_full;

   // Runs from the previous row; the first row of a scan sees none.
   assign first_row = (cell_in.row == '0);
   assign col_plus  = cell_in.col + 1'b1;
   assign last_col  = (col_plus >= cell_in.count);
   assign old_run   = first_row ? '0 : cell_in.run_old;
   assign next_run  = (first_row || last_col) ? '0 : cell_in.run_next;

   // The run ending one row up continues when the cell to the left pairs.
   assign above_diag    = (cell_in.col > cell_in.row);
   assign run_continues = (cell_in.col > (cell_in.row + 1'b1)) && cell_in.prev_pair;

   assign left_full  = cell_in.row - CNT_W'(old_run);
   assign right_full = cell_in.col + CNT_W'(old_run) - 1'b1;

   always_comb begin
      cell_out.pair_now    = above_diag && codes_pair(cell_in.base_row, cell_in.base_col);
      cell_out.run_new     = cell_out.pair_now ? next_run + 1'b1 : '0;
      cell_out.emit        = (old_run != '0) && (old_run >= cell_in.min_length) &&
                             !run_continues;
      cell_out.outer_left  = left_full[7:0];
      cell_out.outer_right = right_full[7:0];
      cell_out.length      = old_run;
   end

endmodule

@@ rtl/rna_stem_helix_finder_unit.sv @@
// ----------------------------------------------------------------------------
// rna_stem_helix_finder_unit
// Loads an RNA sequence and reports its maximal stacked helices one by one.
// ----------------------------------------------------------------------------
// A request beat is taken when start is high and busy is low. Clear and load
// commands give no response and leave busy low. A fetch resumes the
// row-by-row scan of the dot plot and raises busy until it has found the
// next helix of at least min_length pairs, or the end of the plot. Each cell
// takes a memory read step, then an evaluation step in the shared cell unit,
// and the end of the plot is found in a final read step; a full scan of an
// n-long sequence visits n * n cells. The response beat is shown on rsp_data
// for one cycle with rsp_strobe high, in the first cycle in which busy is
// low again; found is low on the beat after the last helix. The receiver
// cannot hold a response off. min_length is written on the csr channel,
// which is always ready, and should only change while busy is low. Reset
// empties the sequence, clears the overflow flag, restores min_length to 3
// and abandons any scan.
// ----------------------------------------------------------------------------
module rna_stem_helix_finder_unit import rshf_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   output logic       busy,
   input  req_type    req_data,
   output logic       rsp_strobe,
   output rsp_type    rsp_data,
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic [7:0] csr_data
);

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_READ = 3'b010,
      ST_EVAL = 3'b100
   } state_type;

   state_type        state_ff, state_in;
   logic [7:0]       min_length_ff;
   logic [CNT_W-1:0] row_ff, row_in;
   logic [CNT_W-1:0] col_ff, col_in;
   logic             started_ff, started_in;
   logic             prev_pair_ff, prev_pair_in;
   logic             rsp_strobe_ff, rsp_strobe_in;
   rsp_type          rsp_ff, rsp_in;

   logic             accept;
   logic             cmd_clear;
   logic             cmd_load;
   logic             cmd_fetch;
   logic [CNT_W-1:0] seq_count;
   logic             overflow;
   logic [3:0]       base_row;
   logic [3:0]       base_col;
   logic [CNT_W-1:0] col_plus;
   logic [RUN_W-1:0] run_mem [MAX_LEN];
   logic [RUN_W-1:0] run_old_ff;
   logic [RUN_W-1:0] run_next_ff;
   logic             run_we;
   cell_in_type      cell_in;
   cell_out_type     cell_out;

   // Request decode.
   assign accept    = start && !busy;
   assign cmd_clear = accept && (req_data.op == OP_CLEAR);
   assign cmd_load  = accept && (req_data.op == OP_LOAD);
   assign cmd_fetch = accept && (req_data.op == OP_FETCH);
   assign busy      = (state_ff != ST_IDLE);
   assign csr_ready = 1'b1;
   assign col_plus  = col_ff + 1'b1;

   // Configuration register.
   always_ff @(posedge clock) begin
      if (reset) begin
         min_length_ff <= 8'd3;
      end else if (csr_valid && csr_ready) begin
         min_length_ff <= csr_data;
      end
   end

   // Sequence memory.
   rshf_base_store u_base_store (
      .clock     (clock),
      .reset     (reset),
      .clear     (cmd_clear),
      .load      (cmd_load),
      .load_char (req_data.base),
      .rd_addr_a (row_ff[ADDR_W-1:0]),
      .rd_addr_b (col_ff[ADDR_W-1:0]),
      .rd_data_a (base_row),
      .rd_data_b (base_col),
      .count     (seq_count),
      .overflow  (overflow)
   );

   // Run lengths per column; every column below the count is rewritten in
   // each row, and the first row ignores what is read.
   assign run_we = (state_ff == ST_EVAL);

   always_ff @(posedge clock) begin
      if (run_we) begin
         run_mem[col_ff[ADDR_W-1:0]] <= cell_out.run_new;
      end
      run_old_ff  <= run_mem[col_ff[ADDR_W-1:0]];
      run_next_ff <= run_mem[col_plus[ADDR_W-1:0]];
   end

   // Shared cell evaluation.
   always_comb begin
      cell_in.row        = row_ff;
      cell_in.col        = col_ff;
      cell_in.count      = seq_count;
      cell_in.base_row   = base_row;
      cell_in.base_col   = base_col;
      cell_in.run_old    = run_old_ff;
      cell_in.run_next   = run_next_ff;
      cell_in.prev_pair  = prev_pair_ff;
      cell_in.min_length = min_length_ff;
   end

   rshf_cell_unit u_cell_unit (
      .cell_in  (cell_in),
      .cell_out (cell_out)
   );

   // Scan sequencer.
   always_comb begin
      state_in      = state_ff;
      row_in        = row_ff;
      col_in        = col_ff;
      started_in    = started_ff;
      prev_pair_in  = prev_pair_ff;
      rsp_strobe_in = 1'b0;
      rsp_in        = rsp_ff;
      case (state_ff)
         ST_IDLE: begin
            if (cmd_clear || cmd_load) begin
               started_in = 1'b0;
            end else if (cmd_fetch) begin
               if (!started_ff) begin
                  row_in       = '0;
                  col_in       = '0;
                  prev_pair_in = 1'b0;
                  started_in   = 1'b1;
               end
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            if (row_ff >= seq_count) begin
               rsp_strobe_in        = 1'b1;
               rsp_in.found         = 1'b0;
               rsp_in.outer_left    = '0;
               rsp_in.outer_right   = '0;
               rsp_in.length        = '0;
               rsp_in.overflow      = overflow;
               state_in             = ST_IDLE;
            end else begin
               state_in = ST_EVAL;
            end
         end
         ST_EVAL: begin
            prev_pair_in = cell_out.pair_now;
            if (col_plus >= seq_count) begin
               col_in = '0;
               row_in = row_ff + 1'b1;
            end else begin
               col_in = col_plus;
            end
            if (cell_out.emit) begin
               rsp_strobe_in      = 1'b1;
               rsp_in.found       = 1'b1;
               rsp_in.outer_left  = cell_out.outer_left;
               rsp_in.outer_right = cell_out.outer_right;
               rsp_in.length      = cell_out.length;
               rsp_in.overflow    = overflow;
               state_in           = ST_IDLE;
            end else begin
               state_in = ST_READ;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         row_ff        <= '0;
         col_ff        <= '0;
         started_ff    <= 1'b0;
         prev_pair_ff  <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         row_ff        <= row_in;
         col_ff        <= col_in;
         started_ff    <= started_in;
         prev_pair_ff  <= prev_pair_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   // Response beat register.
   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_ff;

   // A response beat only follows a cycle of the scan.
   assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> ($past(state_ff) == ST_READ || $past(state_ff) == ST_EVAL))
      else $error("response beat without a scan step");

   // The block is ready again while its response beat is shown.
   assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> !busy)
      else $error("busy during a response beat");

   // A done beat carries no helix.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && !rsp_data.found) |->
         (rsp_data.length == '0 && rsp_data.outer_left == '0 && rsp_data.outer_right == '0))
      else $error("done beat carries helix fields");

   // A reported helix has at least one pair and meets the threshold.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_data.found) |->
         (rsp_data.length != '0 && rsp_data.length >= min_length_ff))
      else $error("helix below the length threshold");

endmodule
